// ===== sv/ssort_pkg.sv =====
`default_nettype none

package ssort_pkg;

    // element width, fixed by the item format
    localparam int unsigned ValueW = 32;

    // input item
    typedef struct packed {
        logic signed [ValueW-1:0] value;
        logic                     last;
    } t_in;

    // result item
    typedef struct packed {
        logic signed [ValueW-1:0] value_res;
        logic                     last_res;
        logic                     truncated;
    } t_out;

    // load request from the sequencer to the output register
    typedef struct packed {
        logic load;
        logic last;
        logic trunc;
    } t_ld;

endpackage

`default_nettype wire

// ===== sv/ssort_ram.sv =====
`default_nettype none

module ssort_ram #(
    parameter int unsigned W = 32,
    parameter int unsigned D = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/ssort_ctrl.sv =====
`default_nettype none

module ssort_ctrl #(
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    input  wire ssort_pkg::t_in                  i_in,
    output logic                                 o_in_stall,
    output logic                                 o_we,
    output logic [$clog2(DEPTH)-1:0]             o_waddr,
    output logic [ssort_pkg::ValueW-1:0]         o_wdata,
    output logic [$clog2(DEPTH)-1:0]             o_raddr,
    input  wire logic [ssort_pkg::ValueW-1:0]    i_rdata,
    output ssort_pkg::t_ld                       o_ld,
    input  wire logic                            i_out_done
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    typedef enum logic [7:0] {
        S_LOAD  = 8'b0000_0001,
        S_GET   = 8'b0000_0010,
        S_CMP   = 8'b0000_0100,
        S_PLACE = 8'b0000_1000,
        S_NEXT  = 8'b0001_0000,
        S_ORD   = 8'b0010_0000,
        S_OLD   = 8'b0100_0000,
        S_OWAIT = 8'b1000_0000
    } t_state;

    t_state                        r_state, n_state;
    logic [CW-1:0]                 r_cnt, n_cnt;
    logic                          r_ovf, n_ovf;
    logic [CW-1:0]                 r_n, n_n;
    logic [AW-1:0]                 r_gap, n_gap;
    logic [AW-1:0]                 r_i, n_i;
    logic [AW-1:0]                 r_j, n_j;
    logic [AW-1:0]                 r_k, n_k;
    logic [ssort_pkg::ValueW-1:0]  r_cur, n_cur;

    logic                          in_xfer;
    logic                          room;
    logic [CW-1:0]                 load_n;
    logic [AW-1:0]                 load_gap;
    logic [AW-1:0]                 j_dn;
    logic [CW-1:0]                 i_up;
    logic [AW-1:0]                 gap_half;
    logic                          k_last;
    logic                          gt;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign room     = r_cnt < CW'(DEPTH);
    assign load_n   = room ? r_cnt + CW'(1) : r_cnt;
    assign load_gap = AW'(load_n >> 1);
    assign j_dn     = r_j - r_gap;
    assign i_up     = CW'(r_i) + CW'(1);
    assign gap_half = r_gap >> 1;
    assign k_last   = (CW'(r_k) + CW'(1)) == r_n;
    // compare unit: element one gap back against the held element
    assign gt       = $signed(i_rdata) > $signed(r_cur);

    assign o_in_stall = (r_state != S_LOAD);

    // sequence load, gapped insertion passes and readout
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        n_n     = r_n;
        n_gap   = r_gap;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_cur   = r_cur;
        o_we    = 1'b0;
        o_waddr = r_j;
        o_wdata = r_cur;
        o_raddr = r_i;
        o_ld    = '0;
        case (r_state)
            S_LOAD: begin
                if (in_xfer) begin
                    if (room) begin
                        o_we    = 1'b1;
                        o_waddr = r_cnt[AW-1:0];
                        o_wdata = i_in.value;
                        n_cnt   = r_cnt + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.last) begin
                        n_n = load_n;
                        if (load_gap == '0) begin
                            n_k     = '0;
                            n_state = S_ORD;
                        end else begin
                            // start the first pass from S_NEXT, after the
                            // last element has landed in the store
                            n_gap   = load_gap;
                            n_i     = load_gap - AW'(1);
                            n_state = S_NEXT;
                        end
                    end
                end
            end
            S_GET: begin
                n_cur   = i_rdata;
                n_j     = r_i;
                o_raddr = r_i - r_gap;
                n_state = S_CMP;
            end
            S_CMP: begin
                o_we = 1'b1;
                if (gt) begin
                    // shift the larger element up one gap
                    o_wdata = i_rdata;
                    n_j     = j_dn;
                    if (j_dn >= r_gap) begin
                        o_raddr = j_dn - r_gap;
                    end else begin
                        n_state = S_PLACE;
                    end
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_PLACE: begin
                o_we    = 1'b1;
                n_state = S_NEXT;
            end
            S_NEXT: begin
                if (i_up < r_n) begin
                    n_i     = i_up[AW-1:0];
                    o_raddr = i_up[AW-1:0];
                    n_state = S_GET;
                end else if (gap_half == '0) begin
                    n_k     = '0;
                    n_state = S_ORD;
                end else begin
                    n_gap   = gap_half;
                    n_i     = gap_half;
                    o_raddr = gap_half;
                    n_state = S_GET;
                end
            end
            S_ORD: begin
                o_raddr = r_k;
                n_state = S_OLD;
            end
            S_OLD: begin
                o_ld.load  = 1'b1;
                o_ld.last  = k_last;
                o_ld.trunc = r_ovf;
                n_state    = S_OWAIT;
            end
            S_OWAIT: begin
                if (i_out_done) begin
                    if (k_last) begin
                        n_cnt   = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + AW'(1);
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
        end
    end

    // indexes and held element
    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_gap <= n_gap;
        r_i   <= n_i;
        r_j   <= n_j;
        r_k   <= n_k;
        r_cur <= n_cur;
    end

endmodule

`default_nettype wire

// ===== sv/shell_sort_engine_top.sv =====
`default_nettype none

// Load: one input transfer per cycle in S_LOAD, one store write each until
//   the store is full; later elements only set the overflow flag.
// Sort: each step: S_GET, S_CMP per compare, S_PLACE at the front, S_NEXT.
// Readout: S_ORD, S_OLD, then S_OWAIT until each result is taken.
// Reset: synchronous, active low; clears count, overflow flag and sequencer.
//   Store contents stay undefined; no clearing pass is run.
module shell_sort_engine_top #(
    parameter int unsigned DEPTH = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire ssort_pkg::t_in  i_in,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output ssort_pkg::t_out      o_out,
    input  wire logic            i_out_stall
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic                          we;
    logic [AW-1:0]                 waddr;
    logic [ssort_pkg::ValueW-1:0]  wdata;
    logic [AW-1:0]                 raddr;
    logic [ssort_pkg::ValueW-1:0]  rdata;
    ssort_pkg::t_ld                ld;
    logic                          out_xfer;
    logic                          r_out_valid;
    ssort_pkg::t_out               r_out;

    assign out_xfer = r_out_valid && !i_out_stall;

    ssort_ram #(
        .W (ssort_pkg::ValueW),
        .D (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    ssort_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_raddr    (raddr),
        .i_rdata    (rdata),
        .o_ld       (ld),
        .i_out_done (out_xfer)
    );

    // hold the result until transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ld.load) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld.load) begin
            r_out.value_res <= $signed(rdata);
            r_out.last_res  <= ld.last;
            r_out.truncated <= ld.trunc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // no input is taken while results are pending
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> o_in_stall)
        else $error("input open while a result is pending");

    // a new result never overwrites one not yet transferred
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld.load |-> !r_out_valid)
        else $error("result register overwritten");

    // the end of a run reopens the input
    a_run_end_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && r_out.last_res) |=> !o_in_stall)
        else $error("input not reopened after run end");

endmodule

`default_nettype wire

// ===== tb/sv/shell_sort_engine_top_tb.sv =====
`timescale 1ns / 100ps

module shell_sort_engine_top_tb;

    localparam int unsigned DEPTH        = 64;
    localparam int unsigned CLK_PERIOD   = 20;
    localparam int unsigned RESET_CYCLES = 5;
    localparam int unsigned ITEM_TARGET  = 330;
    localparam int unsigned IDLE_LIMIT   = 50000;
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam int unsigned MAX_REPORTS  = 10;

    localparam logic signed [ssort_pkg::ValueW-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic signed [ssort_pkg::ValueW-1:0] VAL_MAX = 32'h7fff_ffff;

    // directed sets: single element, extremes, mixed signs, duplicates, descending
    localparam int unsigned DIR_SETS  = 5;
    localparam int unsigned DIR_ITEMS = 21;
    localparam int unsigned dir_set_len [DIR_SETS] = '{1, 2, 6, 5, 7};
    localparam logic signed [ssort_pkg::ValueW-1:0] dir_values [DIR_ITEMS] = '{
        32'sd5,
        VAL_MAX, VAL_MIN,
        32'sd0, -32'sd1, 32'sd1, VAL_MIN, VAL_MAX, -32'sd2,
        32'sd7, 32'sd7, -32'sd3, 32'sd7, -32'sd3,
        32'sd4, 32'sd3, 32'sd2, 32'sd1, 32'sd0, -32'sd1, -32'sd2
    };

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    ssort_pkg::t_in in_item   = '0;
    logic           out_stall = 1'b0;
    logic           in_stall;
    logic           out_valid;
    ssort_pkg::t_out out_item;

    // elements waiting to be driven, sorted results waiting to arrive
    ssort_pkg::t_in  element_q [$];
    ssort_pkg::t_out sorted_q [$];

    // predictor state
    logic signed [ssort_pkg::ValueW-1:0] set_store [DEPTH];
    int unsigned set_count    = 0;
    bit          set_overflow = 1'b0;

    // idle control
    int unsigned in_wait   = 0;
    int unsigned out_hold  = 0;
    int unsigned in_calm   = 0;
    int unsigned out_calm  = 0;

    // run statistics
    int unsigned fault_count    = 0;
    int unsigned elements_sent  = 0;
    int unsigned results_seen   = 0;
    int unsigned sets_done      = 0;
    int unsigned full_sets      = 0;
    int unsigned truncated_sets = 0;
    int unsigned largest_set    = 0;

    shell_sort_engine_top #(
        .DEPTH(DEPTH)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in       (in_item),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .o_out      (out_item),
        .i_out_stall(out_stall)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // draw a per-item wait, with occasional stretches of zero
    function automatic int unsigned draw_wait(ref int unsigned calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 40);
        end
        return $urandom_range(0, 8);
    endfunction

    function automatic logic signed [ssort_pkg::ValueW-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return $urandom;
        end else if (r < 8) begin
            return int'($urandom_range(0, 15)) - 8;
        end
        case ($urandom_range(0, 5))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return VAL_MIN + 1;
            3: return VAL_MAX - 1;
            4: return -32'sd1;
            default: return 32'sd0;
        endcase
    endfunction

    task automatic queue_element(input logic signed [ssort_pkg::ValueW-1:0] v,
                                 input bit is_last);
        ssort_pkg::t_in item;
        item.value = v;
        item.last  = is_last;
        element_q.push_back(item);
    endtask

    task automatic queue_random_set(input int unsigned len);
        for (int unsigned k = 0; k < len; k++) begin
            queue_element(pick_value(), k + 1 == len);
        end
    endtask

    // store one element; on the last one sort the set and queue the run
    task automatic absorb_element(input ssort_pkg::t_in item);
        logic signed [ssort_pkg::ValueW-1:0] swap;
        int gap;
        int j;
        ssort_pkg::t_out res;
        if (set_count < DEPTH) begin
            set_store[set_count] = item.value;
            set_count++;
        end else begin
            set_overflow = 1'b1;
        end
        if (!item.last) begin
            return;
        end
        gap = set_count / 2;
        while (gap > 0) begin
            for (int i = gap; i < set_count; i++) begin
                j = i;
                while (j >= gap && set_store[j - gap] > set_store[j]) begin
                    swap                 = set_store[j - gap];
                    set_store[j - gap]   = set_store[j];
                    set_store[j]         = swap;
                    j                    = j - gap;
                end
            end
            gap = gap / 2;
        end
        for (int unsigned k = 0; k < set_count; k++) begin
            res.value_res = set_store[k];
            res.last_res  = (k + 1 == set_count);
            res.truncated = set_overflow;
            sorted_q.push_back(res);
        end
        sets_done++;
        if (set_count == DEPTH) full_sets++;
        if (set_overflow) truncated_sets++;
        if (set_count > largest_set) largest_set = set_count;
        set_count    = 0;
        set_overflow = 1'b0;
    endtask

    // input driver: present queued elements, idle between transfers
    always @(posedge clk) begin : element_driver
        bit free;
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_item  <= '0;
            in_wait   = 0;
        end else begin
            free = !in_valid;
            if (in_valid && !in_stall) begin
                absorb_element(in_item);
                elements_sent++;
                free    = 1'b1;
                in_wait = draw_wait(in_calm);
            end
            if (free) begin
                if (in_wait == 0 && element_q.size() != 0) begin
                    in_item  <= element_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                    if (in_wait > 0) in_wait--;
                end
            end
        end
    end

    // result monitor: check each transfer against the oldest sorted entry
    always @(posedge clk) begin : result_monitor
        ssort_pkg::t_out want;
        if (!rst_n) begin
            out_stall <= 1'b0;
            out_hold   = 0;
        end else begin
            if (out_valid && !out_stall) begin
                results_seen++;
                if (sorted_q.size() == 0) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS) begin
                        $display("%0t: result with none pending: value %0d last %0b trunc %0b",
                                 $realtime, out_item.value_res, out_item.last_res,
                                 out_item.truncated);
                    end
                end else begin
                    want = sorted_q.pop_front();
                    if (out_item.value_res !== want.value_res
                            || out_item.last_res !== want.last_res
                            || out_item.truncated !== want.truncated) begin
                        fault_count++;
                        if (fault_count <= MAX_REPORTS) begin
                            $display("%0t: mismatch: value %0d/%0d last %0b/%0b trunc %0b/%0b",
                                     $realtime, want.value_res, out_item.value_res,
                                     want.last_res, out_item.last_res,
                                     want.truncated, out_item.truncated);
                        end
                    end
                end
                out_hold = draw_wait(out_calm);
            end
            if (out_hold > 0) begin
                out_hold--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog: end the run when no transfer happens for too long
    initial begin : idle_watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    // build the stimulus, release reset, wait for the last run to drain
    initial begin : run_control
        int unsigned pos;
        int unsigned r;
        pos = 0;
        for (int unsigned s = 0; s < DIR_SETS; s++) begin
            for (int unsigned k = 0; k < dir_set_len[s]; k++) begin
                queue_element(dir_values[pos], k + 1 == dir_set_len[s]);
                pos++;
            end
        end
        // exactly full, then overflowing with the last three elements dropped
        queue_random_set(DEPTH);
        queue_random_set(DEPTH + 3);
        while (element_q.size() < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                queue_random_set($urandom_range(1, 12));
            end else if (r < 88) begin
                queue_random_set($urandom_range(13, 40));
            end else if (r < 95) begin
                queue_random_set($urandom_range(41, DEPTH));
            end else begin
                queue_random_set($urandom_range(DEPTH + 1, DEPTH + 8));
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (element_q.size() != 0 || in_valid) @(posedge clk);
        while (sorted_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sorted %0d sets from %0d input transfers, %0d results checked",
                 sets_done, elements_sent, results_seen);
        $display("full sets %0d, truncated sets %0d, largest set %0d, faults %0d",
                 full_sets, truncated_sets, largest_set, fault_count);
        if (fault_count == 0 && sorted_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== shell_sort_engine_top.f =====
sv/ssort_pkg.sv
sv/ssort_ram.sv
sv/ssort_ctrl.sv
sv/shell_sort_engine_top.sv
tb/sv/shell_sort_engine_top_tb.sv
